/* sv/assert_macros.svh */
// Assertion helpers for the design file that checks its own logic.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/sggc_pkg.sv */
package sggc_pkg;

    // The matrix is square, one row per vertex; the field widths fix it at eight.
    localparam int VERTICES = 8;
    localparam int IDX_W    = $clog2(VERTICES);
    localparam int DEG_W    = 3;
    localparam int MARK_W   = 3;
    localparam int COLOR_W  = 3;
    localparam int COUNT_W  = 4;
    localparam int POP_W    = $clog2(VERTICES + 1);

    localparam logic [MARK_W-1:0] MARK_MAX = MARK_W'(7);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(VERTICES - 1);

    typedef struct packed {
        logic [VERTICES-1:0] adjacency_row;
        logic                last_row;
    } row_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   vertex;
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] colors_used;
        logic               last;
    } result_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_row;
        logic             clear;
        logic             deg_step;
        logic             scan_step;
        logic             assign_color;
        logic             emit_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic out_free;
        logic pick_found;
    } dp_status_t;

endpackage

/* sv/sggc_dp.sv */
module sggc_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sggc_pkg::dp_cmd_t     cmd,
    input  sggc_pkg::row_item_t   row_item,
    input  logic                  result_stall,
    output logic                  result_valid,
    output sggc_pkg::result_item_t result_item,
    output sggc_pkg::dp_status_t  status
);
    import sggc_pkg::*;

    logic [VERTICES-1:0] adj_reg [VERTICES];
    logic [IDX_W-1:0]    row_cnt_reg;
    logic [DEG_W-1:0]    deg_reg  [VERTICES];
    logic [DEG_W-1:0]    deg_next [VERTICES];
    logic [MARK_W-1:0]   mark_reg  [VERTICES];
    logic [MARK_W-1:0]   mark_next [VERTICES];
    logic [COLOR_W-1:0]  color_reg [VERTICES];
    logic [VERTICES-1:0] done_reg;
    logic [COLOR_W-1:0]  top_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic                have_reg;
    logic                out_valid_reg;
    result_item_t        out_item_reg;

    logic [IDX_W-1:0]    rd_addr;
    logic [VERTICES-1:0] rd_row;
    logic [VERTICES-1:0] upper;
    logic [POP_W-1:0]    pop;
    logic                cur_have;
    logic                better;
    logic [VERTICES-1:0] used;
    logic [COLOR_W-1:0]  new_color;
    logic                out_free;

    assign rd_addr = cmd.assign_color ? pick_reg : cmd.idx;
    assign rd_row  = adj_reg[rd_addr];

    // Degree pass: row idx contributes its upper-triangle bits to itself and the far ends.
    always_comb
    begin
        pop = '0;
        for (int k = 0; k < VERTICES; k++)
        begin
            upper[k] = rd_row[k] && (IDX_W'(k) > cmd.idx);
            pop      = pop + POP_W'(upper[k]);
        end
        for (int k = 0; k < VERTICES; k++)
        begin
            if (IDX_W'(k) == cmd.idx)
            begin
                deg_next[k] = deg_reg[k] + DEG_W'(pop);
            end
            else
            begin
                deg_next[k] = deg_reg[k] + DEG_W'(upper[k]);
            end
        end
    end

    // Selection walks one candidate per cycle; strict compares keep the lowest index on ties.
    always_comb
    begin
        cur_have = (cmd.idx == '0) ? 1'b0 : have_reg;
        better   = !done_reg[cmd.idx] &&
                   (!cur_have ||
                    mark_reg[cmd.idx] > mark_reg[pick_reg] ||
                    (mark_reg[cmd.idx] == mark_reg[pick_reg] &&
                     deg_reg[cmd.idx] > deg_reg[pick_reg]));
    end

    // Smallest colour not held by an already coloured neighbor.
    always_comb
    begin
        used = '0;
        for (int j = 0; j < VERTICES; j++)
        begin
            if (rd_row[j] && done_reg[j])
            begin
                used[color_reg[j]] = 1'b1;
            end
        end
        new_color = COLOR_W'(VERTICES - 1);
        for (int c = VERTICES - 1; c >= 0; c--)
        begin
            if (!used[c])
            begin
                new_color = COLOR_W'(c);
            end
        end
        for (int j = 0; j < VERTICES; j++)
        begin
            if (rd_row[j] && mark_reg[j] != MARK_MAX)
            begin
                mark_next[j] = mark_reg[j] + MARK_W'(1);
            end
            else
            begin
                mark_next[j] = mark_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            adj_reg[row_cnt_reg] <= row_item.adjacency_row;
        end
        if (cmd.assign_color)
        begin
            color_reg[pick_reg] <= new_color;
        end
        if (cmd.emit_load)
        begin
            out_item_reg.vertex      <= cmd.idx;
            out_item_reg.color       <= color_reg[cmd.idx];
            out_item_reg.colors_used <= COUNT_W'(top_reg) + COUNT_W'(1);
            out_item_reg.last        <= (cmd.idx == LAST_IDX);
        end
        if (cmd.scan_step && better)
        begin
            pick_reg <= cmd.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            done_reg      <= '0;
            top_reg       <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < VERTICES; k++)
            begin
                deg_reg[k]  <= '0;
                mark_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.load_row)
            begin
                if (row_item.last_row || row_cnt_reg == LAST_IDX)
                begin
                    row_cnt_reg <= '0;
                end
                else
                begin
                    row_cnt_reg <= row_cnt_reg + IDX_W'(1);
                end
            end
            if (cmd.clear)
            begin
                done_reg <= '0;
                top_reg  <= '0;
                for (int k = 0; k < VERTICES; k++)
                begin
                    deg_reg[k]  <= '0;
                    mark_reg[k] <= '0;
                end
            end
            else if (cmd.deg_step)
            begin
                deg_reg <= deg_next;
            end
            else if (cmd.assign_color)
            begin
                mark_reg           <= mark_next;
                done_reg[pick_reg] <= 1'b1;
                if (new_color > top_reg)
                begin
                    top_reg <= new_color;
                end
            end
            if (cmd.scan_step)
            begin
                have_reg <= cur_have || better;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free          = !out_valid_reg || !result_stall;
    assign status.out_free   = out_free;
    assign status.pick_found = have_reg;
    assign result_valid      = out_valid_reg;
    assign result_item       = out_item_reg;

endmodule

/* sv/sggc_ctrl.sv */
module sggc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 row_valid,
    input  logic                 row_last,
    input  sggc_pkg::dp_status_t status,
    output logic                 row_stall,
    output sggc_pkg::dp_cmd_t    cmd
);
    import sggc_pkg::*;

    typedef enum logic [2:0] {
        LOAD,
        DEGREE,
        SCAN,
        ASSIGN,
        EMIT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] pass_reg;
    logic             accept;

    assign accept    = row_valid && (state_reg == LOAD);
    assign row_stall = (state_reg != LOAD);

    assign cmd.load_row     = accept;
    assign cmd.clear        = accept && row_last;
    assign cmd.deg_step     = (state_reg == DEGREE);
    assign cmd.scan_step    = (state_reg == SCAN);
    assign cmd.assign_color = (state_reg == ASSIGN);
    assign cmd.emit_load    = (state_reg == EMIT) && status.out_free;
    assign cmd.idx          = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LOAD;
            idx_reg   <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                LOAD:
                begin
                    if (accept && row_last)
                    begin
                        state_reg <= DEGREE;
                        idx_reg   <= '0;
                    end
                end
                DEGREE:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= SCAN;
                        pass_reg  <= '0;
                    end
                end
                SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ASSIGN;
                    end
                end
                ASSIGN:
                begin
                    idx_reg  <= '0;
                    pass_reg <= pass_reg + IDX_W'(1);
                    if (pass_reg == LAST_IDX)
                    begin
                        state_reg <= EMIT;
                    end
                    else
                    begin
                        state_reg <= SCAN;
                    end
                end
                EMIT:
                begin
                    if (status.out_free)
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= LOAD;
                end
            endcase
        end
    end

endmodule

/* sv/saturation_greedy_graph_coloring.sv */
// Saturation-greedy graph colorer for an eight-vertex graph. Rows of the adjacency matrix
// arrive one per transfer and are taken at one per cycle. The transfer that carries
// last_row starts coloring, and eight results follow. The results come out in vertex
// order, and the last one is flagged. The sequencer first counts degrees, one stored row
// per cycle. It then runs eight passes. Each pass walks over the vertices to select the
// next one and then gives that vertex a color. Finally it loads the output register
// with each result in turn, holding while the output is stalled.
// While coloring and emitting, row_stall is high. Once the final result sits in the
// output register, new rows are taken again.
module saturation_greedy_graph_coloring (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   row_valid,
    output logic                   row_stall,
    input  sggc_pkg::row_item_t    row_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output sggc_pkg::result_item_t result_item
);
    import sggc_pkg::*;

    // Commands and status are the only link between sequencer and datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    sggc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_last  (row_item.last_row),
        .status    (status),
        .row_stall (row_stall),
        .cmd       (cmd)
    );

    // The datapath holds the stored rows, degrees, marks, colors and the output register.
    sggc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .row_item     (row_item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_item  (result_item),
        .status       (status)
    );

`include "assert_macros.svh"

    // A color is only ever given after a selection walk found an uncolored vertex.
    `ASSERT_IMPLIES(a_pick_before_assign, cmd.assign_color, status.pick_found, "no pick")
    // Results are only loaded when the output register can take them.
    `ASSERT_IMPLIES(a_emit_has_room, cmd.emit_load, status.out_free, "emit overwrote a result")
    // Rows are never written while coloring is under way.
    `ASSERT_IMPLIES(a_no_row_while_busy, cmd.load_row, !(cmd.scan_step || cmd.assign_color), "busy")
    // At least one color is always in use.
    `ASSERT_IMPLIES(a_colors_nonzero, result_valid, result_item.colors_used != '0, "no colors")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

// Self-checking bench for the saturation-greedy graph colorer.
module tb_top;

    import sggc_pkg::*;

    // Stimulus size and the number of cycles with no transfer on either channel before
    // the run is declared hung. The limit leaves a wide margin for the time a matrix spends
    // being colored, in which no transfer occurs, and for random stalls.
    localparam int TOTAL_ITEMS    = 230;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int IDLE_PERCENT   = 21;

    // The scoreboard keeps its own copy of the stored matrix and row pointer. Each row
    // transfer is written into that copy; a row flagged as last colors the copy and
    // queues the eight results the block must produce, in vertex order.
    class coloring_scoreboard;
        logic [VERTICES-1:0] stored_rows[VERTICES];
        int                  next_row;
        result_item_t        expected_results[$];
        int                  errors;

        function new();
            stored_rows = '{default: '0};
            next_row    = 0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Greedy coloring by saturation: the uncolored vertex with the most marks from
        // colored neighbors goes first, ties broken by upper-triangle degree and then by
        // the lowest index. Marks follow the chosen vertex's own row and saturate.
        function void color_matrix();
            int           degree[VERTICES];
            int           marks[VERTICES];
            int           hue[VERTICES];
            bit           done[VERTICES];
            int           pick;
            int           c;
            bit           free_hue;
            int           top;
            result_item_t res;

            for (int i = 0; i < VERTICES; i++)
            begin
                degree[i] = 0;
                marks[i]  = 0;
                hue[i]    = 0;
                done[i]   = 1'b0;
            end

            for (int i = 0; i < VERTICES; i++)
                for (int j = i + 1; j < VERTICES; j++)
                    if (stored_rows[i][j])
                    begin
                        degree[i]++;
                        degree[j]++;
                    end

            for (int pass = 0; pass < VERTICES; pass++)
            begin
                pick = -1;
                for (int i = 0; i < VERTICES; i++)
                begin
                    if (!done[i] && (pick < 0 || marks[i] > marks[pick] ||
                        (marks[i] == marks[pick] && degree[i] > degree[pick])))
                        pick = i;
                end
                if (pick < 0)
                    break;

                // A self loop never blocks a color, since the vertex is not done yet.
                for (c = 0; c < VERTICES; c++)
                begin
                    free_hue = 1'b1;
                    for (int j = 0; j < VERTICES; j++)
                        if (stored_rows[pick][j] && done[j] && hue[j] == c)
                            free_hue = 1'b0;
                    if (free_hue)
                        break;
                end
                if (c >= VERTICES)
                    c = VERTICES - 1;
                hue[pick]  = c;
                done[pick] = 1'b1;

                for (int j = 0; j < VERTICES; j++)
                    if (stored_rows[pick][j] && marks[j] < int'(MARK_MAX))
                        marks[j]++;
            end

            top = 0;
            for (int i = 0; i < VERTICES; i++)
                if (hue[i] > top)
                    top = hue[i];

            for (int i = 0; i < VERTICES; i++)
            begin
                res.vertex      = IDX_W'(i);
                res.color       = COLOR_W'(hue[i]);
                res.colors_used = COUNT_W'(top + 1);
                res.last        = (i == VERTICES - 1);
                expected_results.push_back(res);
            end
        endfunction

        function void note_row(row_item_t item);
            stored_rows[next_row] = item.adjacency_row;
            next_row = (next_row + 1) % VERTICES;
            if (item.last_row)
            begin
                next_row = 0;
                color_matrix();
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;

            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: vertex %0d color %0d used %0d last %0d",
                         $time, got.vertex, got.color, got.colors_used, got.last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.vertex !== want.vertex)
            begin
                $display("%0t: vertex expected %0d actual %0d", $time, want.vertex, got.vertex);
                errors++;
            end
            if (got.color !== want.color)
            begin
                $display("%0t: color of vertex %0d expected %0d actual %0d",
                         $time, want.vertex, want.color, got.color);
                errors++;
            end
            if (got.colors_used !== want.colors_used)
            begin
                $display("%0t: colors_used at vertex %0d expected %0d actual %0d",
                         $time, want.vertex, want.colors_used, got.colors_used);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last at vertex %0d expected %0d actual %0d",
                         $time, want.vertex, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         row_valid;
    logic         row_stall;
    row_item_t    row_item;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_item;

    coloring_scoreboard sb;
    int                 rows_sent;
    int                 results_seen;
    int                 quiet_cycles;

    saturation_greedy_graph_coloring dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .row_valid    (row_valid),
        .row_stall    (row_stall),
        .row_item     (row_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Each side has a stretch with no idling at all: the sender for a run of rows in the
    // middle of the random part, the receiver for a run of results.
    function bit sender_calm();
        return rows_sent >= 100 && rows_sent < 150;
    endfunction

    function bit receiver_calm();
        return results_seen >= 64 && results_seen < 160;
    endfunction

    // The receiver stalls at random. Its stall only changes on the falling edge.
    always @(negedge clk)
    begin
        result_stall <= !receiver_calm() && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Monitor. Every transfer on either channel is seen at the rising edge with the values
    // that held before the edge. A row transfer is noted first, so its prediction is ready
    // before any result can arrive. The watchdog counts edges with no transfer at all.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (row_valid && !row_stall)
            begin
                sb.note_row(row_item);
                quiet_cycles = 0;
            end
            if (result_valid && !result_stall)
            begin
                sb.check_result(result_item);
                results_seen++;
                quiet_cycles = 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results still expected",
                         $time, WATCHDOG_LIMIT, sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offers one row and returns at the falling edge after its transfer. It is entered at
    // a falling edge. Random idle cycles come first; valid is lowered once per idle cycle
    // and raised only after the idling ends, so it never drops and rises in one step.
    task automatic send_row(input logic [VERTICES-1:0] row, input logic last);
        while (!sender_calm() && $urandom_range(99) < IDLE_PERCENT)
        begin
            row_valid = 1'b0;
            @(negedge clk);
        end
        row_valid = 1'b1;
        row_item  = '{adjacency_row: row, last_row: last};
        @(posedge clk);
        while (row_stall)
            @(posedge clk);
        rows_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [VERTICES-1:0] mat[VERTICES];
        int                  kind;
        int                  density;
        int                  len;

        sb           = new();
        rows_sent    = 0;
        results_seen = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        row_valid    = 1'b0;
        row_item     = '0;
        result_stall = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Complete graph without self loops: every vertex needs its own color. It also
        // writes all eight rows, so no later early last row reads an unwritten row.
        for (int i = 0; i < VERTICES; i++)
            send_row(~(VERTICES'(1) << i), i == VERTICES - 1);

        // Early last row on row 0: the other rows keep the complete graph, so the
        // matrix is no longer symmetric and vertex 0 has no edges of its own.
        send_row('0, 1'b1);

        // Nine rows of all ones, self loops included: the ninth wraps onto row 0.
        // Marks reach their saturation value here.
        for (int i = 0; i < VERTICES + 1; i++)
            send_row('1, i == VERTICES);

        // Empty graph: one color for everyone.
        for (int i = 0; i < VERTICES; i++)
            send_row('0, i == VERTICES - 1);

        // Random matrices. Most are well-formed symmetric graphs of eight rows with a
        // random edge density; the rest are short or overlong matrices, random
        // asymmetric rows, and the odd self loop.
        while (rows_sent < TOTAL_ITEMS)
        begin
            kind    = $urandom_range(99);
            density = $urandom_range(100);
            if (kind < 70)
                len = VERTICES;
            else if (kind < 85)
                len = $urandom_range(VERTICES - 1, 1);
            else
                len = $urandom_range(VERTICES + 4, VERTICES + 1);

            for (int i = 0; i < VERTICES; i++)
                mat[i] = '0;
            for (int i = 0; i < VERTICES; i++)
                for (int j = i + 1; j < VERTICES; j++)
                    if ($urandom_range(99) < density)
                    begin
                        mat[i][j] = 1'b1;
                        mat[j][i] = 1'b1;
                    end
            if ($urandom_range(99) < 10)
            begin
                kind = $urandom_range(VERTICES - 1);
                mat[kind][kind] = 1'b1;
            end
            if ($urandom_range(99) < 15)
                for (int i = 0; i < VERTICES; i++)
                    mat[i] = VERTICES'($urandom_range(255));

            for (int k = 0; k < len; k++)
                send_row(mat[k % VERTICES], k == len - 1);
        end
        row_valid = 1'b0;

        // Drain: wait for every expected result, then a little longer so that a stray
        // extra result would still be caught. The watchdog covers a hang here.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
